// File: rtl/rbd_pkg.sv
// rbd_pkg: shared types and constants of the run-length byte decoder.
// Used by rbd_ctrl, rbd_datapath and rle_byte_decoder; depends on nothing.
package rbd_pkg;

  localparam int ADDR_BITS_DEF = 17;
  localparam int LANES_DEF     = 4;

  // Byte lanes carried by one result word.
  localparam int SLOTS       = 4;
  localparam int LANE_IDX_W  = $clog2(SLOTS);
  localparam int LANE_CNT_W  = $clog2(SLOTS + 1);

  localparam int BYTE_W      = 8;
  localparam int CFG_W       = 16;
  localparam int CFG_IDX_W   = 2;
  // row * stride + column stays below 2^32 because row never exceeds 65534.
  localparam int VADDR_W     = 32;

  localparam logic [CFG_IDX_W-1:0] CFG_VERTICAL = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_STRIDE   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_WRAP     = 2'd2;

  localparam logic [BYTE_W-1:0] END_BYTE    = 8'hFF;
  localparam int                LIT_BIT     = 7;
  localparam logic [BYTE_W-1:0] LIT_MASK    = 8'h7F;
  localparam logic [BYTE_W-1:0] LIT_BIAS    = 8'd1;
  localparam logic [BYTE_W-1:0] REPEAT_BIAS = 8'd2;

  typedef struct packed {
    logic take_byte;
    logic recalc_mul;
    logic recalc_add;
    logic load_lit;
    logic load_rep;
    logic lane_step;
    logic emit_data;
    logic emit_last;
    logic emit_end;
  } cmd_t;

  typedef struct packed {
    logic dirty;
    logic byte_end;
    logic byte_lit;
    logic run_one;
    logic run_zero;
    logic chunk_full;
    logic out_free;
  } sts_t;

endpackage

// File: rtl/rbd_ctrl.sv
// rbd_ctrl: sequencer of the run-length byte decoder.
// Tracks the stream phase and drives rbd_datapath; uses rbd_pkg.
module rbd_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  input  rbd_pkg::sts_t sts,
  output rbd_pkg::cmd_t cmd
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECODE,
    S_MUL,
    S_ADD,
    S_LANE,
    S_EMIT,
    S_END
  } state_t;

  typedef enum logic [1:0] {
    PH_CTRL,
    PH_REPEAT,
    PH_LITERAL
  } phase_t;

  state_t state, state_next;
  phase_t phase, phase_next;

  assign in_ready = (state == S_IDLE);

  always_comb begin
    cmd        = '0;
    state_next = state;
    phase_next = phase;
    unique case (state)
      S_IDLE: begin
        cmd.take_byte = in_valid;
        if (in_valid) begin
          state_next = S_DECODE;
        end
      end
      S_DECODE: begin
        // refresh the vertical address after any register write
        if (sts.dirty) begin
          state_next = S_MUL;
        end else begin
          unique case (phase)
            PH_CTRL: begin
              if (sts.byte_end) begin
                state_next = S_END;
              end else if (sts.byte_lit) begin
                cmd.load_lit = 1'b1;
                phase_next   = PH_LITERAL;
                state_next   = S_IDLE;
              end else begin
                cmd.load_rep = 1'b1;
                phase_next   = PH_REPEAT;
                state_next   = S_IDLE;
              end
            end
            default: begin
              state_next = S_LANE;
            end
          endcase
        end
      end
      S_MUL: begin
        cmd.recalc_mul = 1'b1;
        state_next     = S_ADD;
      end
      S_ADD: begin
        cmd.recalc_add = 1'b1;
        state_next     = S_DECODE;
      end
      S_LANE: begin
        cmd.lane_step = 1'b1;
        if (phase == PH_LITERAL || sts.chunk_full || sts.run_one) begin
          state_next = S_EMIT;
        end
      end
      S_EMIT: begin
        cmd.emit_last = (phase == PH_LITERAL) || sts.run_zero;
        if (sts.out_free) begin
          cmd.emit_data = 1'b1;
          if (sts.run_zero) begin
            phase_next = PH_CTRL;
          end
          if (phase == PH_LITERAL || sts.run_zero) begin
            state_next = S_IDLE;
          end else begin
            state_next = S_LANE;
          end
        end
      end
      S_END: begin
        if (sts.out_free) begin
          cmd.emit_end = 1'b1;
          phase_next   = PH_CTRL;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      phase <= PH_CTRL;
    end else begin
      state <= state_next;
      phase <= phase_next;
    end
  end

endmodule

// File: rtl/rbd_datapath.sv
// rbd_datapath: registers, address counters, lane builder and result register.
// Driven by rbd_ctrl through rbd_pkg::cmd_t; uses rbd_pkg.
module rbd_datapath #(
  parameter int ADDR_BITS = rbd_pkg::ADDR_BITS_DEF,
  parameter int LANES     = rbd_pkg::LANES_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_write_en,
  input  logic [rbd_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [rbd_pkg::CFG_W-1:0]           cfg_data,
  input  logic [rbd_pkg::BYTE_W-1:0]          data_byte,
  input  logic                                out_ready,
  input  rbd_pkg::cmd_t                       cmd,
  output rbd_pkg::sts_t                       sts,
  output logic                                out_valid,
  output logic [rbd_pkg::LANE_CNT_W-1:0]      out_count,
  output logic [rbd_pkg::BYTE_W-1:0]          out_val  [rbd_pkg::SLOTS],
  output logic [ADDR_BITS-1:0]                out_addr [rbd_pkg::SLOTS],
  output logic                                out_last,
  output logic                                out_end,
  output logic                                out_ovf
);

  localparam int PER_INT = (LANES < rbd_pkg::SLOTS) ? LANES : rbd_pkg::SLOTS;
  localparam logic [rbd_pkg::LANE_CNT_W-1:0] PER_LANES = rbd_pkg::LANE_CNT_W'(PER_INT);

  // configuration
  logic                        vmode;
  logic [rbd_pkg::CFG_W-1:0]   stride;
  logic [rbd_pkg::CFG_W-1:0]   wrap;
  logic                        dirty;

  // stream state
  logic [rbd_pkg::BYTE_W-1:0]  cur_byte;
  logic [rbd_pkg::BYTE_W-1:0]  run_left;
  logic [ADDR_BITS-1:0]        linear_pos;
  logic [rbd_pkg::CFG_W-1:0]   row_pos;
  logic [rbd_pkg::CFG_W-1:0]   column_pos;
  logic [rbd_pkg::VADDR_W-1:0] vaddr;
  logic [rbd_pkg::VADDR_W-1:0] prod;
  logic                        ovf;

  // lane builder
  logic [rbd_pkg::LANE_CNT_W-1:0] lane_cnt;
  logic [rbd_pkg::BYTE_W-1:0]     build_val  [rbd_pkg::SLOTS];
  logic [ADDR_BITS-1:0]           build_addr [rbd_pkg::SLOTS];

  // address step for one lane
  logic                        v_over;
  logic                        row_wrap;
  logic [rbd_pkg::CFG_W-1:0]   column_inc;
  logic [ADDR_BITS-1:0]        linear_inc;
  logic [ADDR_BITS-1:0]        lane_addr;
  logic                        out_free;

  assign v_over     = |vaddr[rbd_pkg::VADDR_W-1:ADDR_BITS];
  assign row_wrap   = ({1'b0, row_pos} + 17'd1) >= {1'b0, wrap};
  assign column_inc = column_pos + 16'd1;
  assign linear_inc = linear_pos + ADDR_BITS'(1);
  assign lane_addr  = vmode ? vaddr[ADDR_BITS-1:0] : linear_pos;
  assign out_free   = !out_valid || out_ready;

  always_comb begin
    sts            = '0;
    sts.dirty      = dirty;
    sts.byte_end   = (cur_byte == rbd_pkg::END_BYTE);
    sts.byte_lit   = cur_byte[rbd_pkg::LIT_BIT];
    sts.run_one    = (run_left == 8'd1);
    sts.run_zero   = (run_left == 8'd0);
    sts.chunk_full = (lane_cnt + rbd_pkg::LANE_CNT_W'(1)) >= PER_LANES;
    sts.out_free   = out_free;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vmode  <= 1'b0;
      stride <= 16'd1;
      wrap   <= 16'd1;
    end else if (cfg_write_en) begin
      unique case (cfg_index)
        rbd_pkg::CFG_VERTICAL: vmode  <= cfg_data[0];
        rbd_pkg::CFG_STRIDE:   stride <= cfg_data;
        rbd_pkg::CFG_WRAP:     wrap   <= cfg_data;
        default: ;
      endcase
    end
  end

  // a write arriving during the refresh wins, so the refresh runs again
  always_ff @(posedge clk) begin
    if (rst) begin
      dirty <= 1'b0;
    end else if (cfg_write_en) begin
      dirty <= 1'b1;
    end else if (cmd.recalc_add) begin
      dirty <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.take_byte) begin
      cur_byte <= data_byte;
    end
    if (cmd.recalc_mul) begin
      prod <= rbd_pkg::VADDR_W'(row_pos) * rbd_pkg::VADDR_W'(stride);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      run_left   <= '0;
      linear_pos <= '0;
      row_pos    <= '0;
      column_pos <= '0;
      vaddr      <= '0;
      ovf        <= 1'b0;
    end else begin
      if (cmd.load_lit) begin
        run_left <= (cur_byte & rbd_pkg::LIT_MASK) + rbd_pkg::LIT_BIAS;
      end else if (cmd.load_rep) begin
        run_left <= cur_byte + rbd_pkg::REPEAT_BIAS;
      end
      if (cmd.recalc_add) begin
        vaddr <= prod + {16'd0, column_pos};
      end
      if (cmd.lane_step) begin
        run_left <= run_left - 8'd1;
        if (vmode) begin
          if (v_over) begin
            ovf <= 1'b1;
          end
          if (row_wrap) begin
            row_pos    <= '0;
            column_pos <= column_inc;
            vaddr      <= {16'd0, column_inc};
            if (column_inc == 16'd0) begin
              ovf <= 1'b1;
            end
          end else begin
            row_pos <= row_pos + 16'd1;
            vaddr   <= vaddr + {16'd0, stride};
          end
        end else begin
          linear_pos <= linear_inc;
          if (linear_inc == '0) begin
            ovf <= 1'b1;
          end
        end
      end
      if (cmd.emit_end) begin
        run_left   <= '0;
        linear_pos <= '0;
        row_pos    <= '0;
        column_pos <= '0;
        vaddr      <= '0;
        ovf        <= 1'b0;
      end
    end
  end

  // gather lanes; clear them as they move to the result register
  always_ff @(posedge clk) begin
    if (rst || cmd.emit_data) begin
      lane_cnt <= '0;
      for (int i = 0; i < rbd_pkg::SLOTS; i++) begin
        build_val[i]  <= '0;
        build_addr[i] <= '0;
      end
    end else if (cmd.lane_step) begin
      build_val[lane_cnt[rbd_pkg::LANE_IDX_W-1:0]]  <= cur_byte;
      build_addr[lane_cnt[rbd_pkg::LANE_IDX_W-1:0]] <= lane_addr;
      lane_cnt <= lane_cnt + rbd_pkg::LANE_CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit_data || cmd.emit_end) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit_data) begin
      out_count <= lane_cnt;
      out_val   <= build_val;
      out_addr  <= build_addr;
      out_last  <= cmd.emit_last;
      out_end   <= 1'b0;
      out_ovf   <= ovf;
    end else if (cmd.emit_end) begin
      out_count <= '0;
      for (int i = 0; i < rbd_pkg::SLOTS; i++) begin
        out_val[i]  <= '0;
        out_addr[i] <= '0;
      end
      out_addr[0] <= lane_addr;
      out_last    <= 1'b1;
      out_end     <= 1'b1;
      out_ovf     <= ovf || (vmode && v_over);
    end
  end

endmodule

// File: rtl/rle_byte_decoder.sv
// rle_byte_decoder: top level of the PackBits-style run-length byte decoder.
// Instantiates rbd_ctrl and rbd_datapath; uses rbd_pkg.
//
// Takes one compressed byte per input word and returns decoded bytes with their
// output addresses, up to four per result word. A control byte passes the idle
// and decode states, the end byte also the end state, a literal byte idle,
// decode, lane and emit; a repeat steps the address unit one byte lane per
// cycle in the lane state and loads each result word in the emit state. The
// first byte after a register write also passes the multiply and add states
// while row * stride + column is rebuilt. A finished result waits in the output
// register while the next byte is already taken in; a result that finds the
// register still full holds the sequencer until the receiver takes the word.
module rle_byte_decoder #(
  parameter int ADDR_BITS = rbd_pkg::ADDR_BITS_DEF,
  parameter int LANES     = rbd_pkg::LANES_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_write_en,
  input  logic [rbd_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [rbd_pkg::CFG_W-1:0]       cfg_data,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [rbd_pkg::BYTE_W-1:0]      data_byte,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [rbd_pkg::LANE_CNT_W-1:0]  lane_count,
  output logic [rbd_pkg::BYTE_W-1:0]      value_zero,
  output logic [rbd_pkg::BYTE_W-1:0]      value_one,
  output logic [rbd_pkg::BYTE_W-1:0]      value_two,
  output logic [rbd_pkg::BYTE_W-1:0]      value_three,
  output logic [ADDR_BITS-1:0]            addr_zero,
  output logic [ADDR_BITS-1:0]            addr_one,
  output logic [ADDR_BITS-1:0]            addr_two,
  output logic [ADDR_BITS-1:0]            addr_three,
  output logic                            last_of_item,
  output logic                            stream_end,
  output logic                            overflow
);

  rbd_pkg::cmd_t              cmd;
  rbd_pkg::sts_t              sts;
  logic [rbd_pkg::BYTE_W-1:0] out_val  [rbd_pkg::SLOTS];
  logic [ADDR_BITS-1:0]       out_addr [rbd_pkg::SLOTS];

  rbd_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  rbd_datapath #(
    .ADDR_BITS (ADDR_BITS),
    .LANES     (LANES)
  ) u_datapath (
    .clk          (clk),
    .rst          (rst),
    .cfg_write_en (cfg_write_en),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .data_byte    (data_byte),
    .out_ready    (out_ready),
    .cmd          (cmd),
    .sts          (sts),
    .out_valid    (out_valid),
    .out_count    (lane_count),
    .out_val      (out_val),
    .out_addr     (out_addr),
    .out_last     (last_of_item),
    .out_end      (stream_end),
    .out_ovf      (overflow)
  );

  assign value_zero  = out_val[0];
  assign value_one   = out_val[1];
  assign value_two   = out_val[2];
  assign value_three = out_val[3];
  assign addr_zero   = out_addr[0];
  assign addr_one    = out_addr[1];
  assign addr_two    = out_addr[2];
  assign addr_three  = out_addr[3];

endmodule
